### rtl/core/symbol_string_lexer_macros.svh
// Assertion macros used by the lexer checker
`ifndef SYMBOL_STRING_LEXER_MACROS_SVH
`define SYMBOL_STRING_LEXER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

### rtl/core/ssl_pkg.sv
// Types and constants of the symbol and string lexer
package ssl_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KEYWORD_BYTES_DEF = 8;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 64;
  localparam int KW_LEN_BITS    = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_KW0_TEXT = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KW0_LEN  = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KW1_TEXT = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KW1_LEN  = 8'd3;

  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_KNOWN  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOQUOTE = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_UNUSED  = 2'd3;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_SYMBOL = 4'b0100,
    MODE_FAILED = 4'b1000
  } mode_e;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_symbol_char(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E) && (c != CHAR_QUOTE) && (c != 8'h5B) && (c != 8'h5D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

### rtl/core/symbol_string_lexer.sv
// Symbol and string lexer: one source byte per transaction, token results out
//
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | text_byte_i, end_of_text_i
//  out     | out       | out_valid_o/out_ready_i | token_kind_o .. stream_done_o
//
// One byte is taken per cycle while in_ready_o is high; its zero, one or two
// results enter a 4-entry result queue at that edge and wait behind older ones.
// in_ready_o drops while the queue has fewer than two free entries.
// Reset clears the scan state, keywords and queue; no clearing pass.
// cfg_ready_o is always high.
module symbol_string_lexer #(
  parameter int POSITION_BITS = ssl_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_BYTES = ssl_pkg::KEYWORD_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ssl_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [ssl_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          text_byte_i,
  input  logic                                end_of_text_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          token_kind_o,
  output logic                                keyword_index_o,
  output logic [POSITION_BITS-1:0]            token_start_o,
  output logic [POSITION_BITS-1:0]            token_length_o,
  output logic [1:0]                          parse_status_o,
  output logic                                stream_done_o
);

  localparam int PREFIX_BITS = 8 * KEYWORD_BYTES;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POSITION_BITS'(1);
  endfunction

  function automatic logic kw_match(input logic [PREFIX_BITS-1:0]             text,
                                    input logic [ssl_pkg::KW_LEN_BITS-1:0]   len,
                                    input logic [POSITION_BITS-1:0]          run,
                                    input logic [PREFIX_BITS-1:0]            prefix);
    logic eq;
    eq = (len != '0) && (len <= ssl_pkg::KW_LEN_BITS'(KEYWORD_BYTES)) &&
         (run == POSITION_BITS'(len));
    for (int i = 0; i < KEYWORD_BYTES; i++) begin
      if ((ssl_pkg::KW_LEN_BITS'(i) < len) && (text[8*i +: 8] != prefix[8*i +: 8])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  // configuration registers
  logic [ssl_pkg::CFG_DATA_BITS-1:0] kw0_text_q, kw1_text_q;
  logic [ssl_pkg::KW_LEN_BITS-1:0]   kw0_len_q, kw1_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw0_text_q <= '0;
      kw0_len_q  <= '0;
      kw1_text_q <= '0;
      kw1_len_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssl_pkg::REG_KW0_TEXT: kw0_text_q <= cfg_data_i;
        ssl_pkg::REG_KW0_LEN:  kw0_len_q  <= cfg_data_i[ssl_pkg::KW_LEN_BITS-1:0];
        ssl_pkg::REG_KW1_TEXT: kw1_text_q <= cfg_data_i;
        ssl_pkg::REG_KW1_LEN:  kw1_len_q  <= cfg_data_i[ssl_pkg::KW_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  ssl_pkg::mode_e           mode_q, mode_n, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_n, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_n, start_d;
  logic [POSITION_BITS-1:0] run_q, run_n, run_d;
  logic [PREFIX_BITS-1:0]   prefix_q, prefix_n, prefix_d;

  logic in_fire;
  logic handled, failed_in;
  logic str_close, sym_mid, sym_end;
  logic end_valid;
  logic [POSITION_BITS-1:0] end_start, end_len;
  logic [1:0] end_status;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    mode_n     = mode_q;
    start_n    = start_q;
    run_n      = run_q;
    prefix_n   = prefix_q;
    handled    = 1'b0;
    failed_in  = 1'b0;
    str_close  = 1'b0;
    sym_mid    = 1'b0;
    sym_end    = 1'b0;
    end_valid  = 1'b0;
    end_start  = '0;
    end_len    = '0;
    end_status = ssl_pkg::STATUS_OK;

    case (mode_q)
      ssl_pkg::MODE_FAILED: begin
        failed_in = 1'b1;
        handled   = 1'b1;
      end
      ssl_pkg::MODE_STRING: begin
        if (text_byte_i == ssl_pkg::CHAR_QUOTE) begin
          str_close = 1'b1;
          mode_n    = ssl_pkg::MODE_IDLE;
        end else begin
          run_n = sat_inc(run_q);
        end
        handled = 1'b1;
      end
      ssl_pkg::MODE_SYMBOL: begin
        if (ssl_pkg::is_symbol_char(text_byte_i)) begin
          for (int i = 0; i < KEYWORD_BYTES; i++) begin
            if (run_q == POSITION_BITS'(i)) begin
              prefix_n[8*i +: 8] = text_byte_i;
            end
          end
          run_n   = sat_inc(run_q);
          handled = 1'b1;
        end else begin
          sym_mid = 1'b1;
          mode_n  = ssl_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (!handled) begin
      if (ssl_pkg::is_space(text_byte_i)) begin
        mode_n = mode_n;
      end else if (text_byte_i == ssl_pkg::CHAR_QUOTE) begin
        mode_n  = ssl_pkg::MODE_STRING;
        start_n = pos_q;
        run_n   = '0;
      end else if (ssl_pkg::is_symbol_char(text_byte_i) && !ssl_pkg::is_digit(text_byte_i)) begin
        mode_n   = ssl_pkg::MODE_SYMBOL;
        start_n  = pos_q;
        run_n    = POSITION_BITS'(1);
        prefix_n = PREFIX_BITS'(text_byte_i);
      end else begin
        end_valid  = 1'b1;
        end_start  = pos_q;
        end_status = ssl_pkg::STATUS_UNKNOWN;
        mode_n     = ssl_pkg::MODE_FAILED;
      end
    end

    pos_n = failed_in ? pos_q : sat_inc(pos_q);

    if (!failed_in && (mode_n != ssl_pkg::MODE_FAILED) && end_of_text_i) begin
      end_valid = 1'b1;
      if (mode_n == ssl_pkg::MODE_STRING) begin
        end_start  = start_n;
        end_len    = run_n;
        end_status = ssl_pkg::STATUS_NOQUOTE;
      end else begin
        sym_end    = (mode_n == ssl_pkg::MODE_SYMBOL);
        end_start  = pos_n;
        end_status = ssl_pkg::STATUS_OK;
      end
    end

    if (end_of_text_i) begin
      mode_d   = ssl_pkg::MODE_IDLE;
      pos_d    = '0;
      start_d  = '0;
      run_d    = '0;
      prefix_d = '0;
    end else begin
      mode_d   = mode_n;
      pos_d    = pos_n;
      start_d  = start_n;
      run_d    = run_n;
      prefix_d = prefix_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ssl_pkg::MODE_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      run_q    <= '0;
      prefix_q <= '0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      run_q    <= run_d;
      prefix_q <= prefix_d;
    end
  end

  // token result: closed string or finished symbol
  logic                     tok_valid, tok_kw_idx, hit0, hit1;
  logic [1:0]               tok_kind;
  logic [POSITION_BITS-1:0] tok_start, tok_len;
  logic [PREFIX_BITS-1:0]   tok_prefix;

  always_comb begin
    tok_valid  = str_close || sym_mid || sym_end;
    tok_start  = sym_end ? start_n : start_q;
    tok_len    = sym_end ? run_n : run_q;
    tok_prefix = sym_end ? prefix_n : prefix_q;
    hit0 = kw_match(kw0_text_q[PREFIX_BITS-1:0], kw0_len_q, tok_len, tok_prefix);
    hit1 = kw_match(kw1_text_q[PREFIX_BITS-1:0], kw1_len_q, tok_len, tok_prefix);
    tok_kw_idx = 1'b0;
    if (str_close) begin
      tok_kind = ssl_pkg::KIND_STRING;
    end else if (hit0) begin
      tok_kind = ssl_pkg::KIND_KNOWN;
    end else if (hit1) begin
      tok_kind   = ssl_pkg::KIND_KNOWN;
      tok_kw_idx = 1'b1;
    end else begin
      tok_kind = ssl_pkg::KIND_SYMBOL;
    end
  end

  // result queue
  logic [1:0]               q_kind   [ssl_pkg::FIFO_DEPTH];
  logic                     q_kw     [ssl_pkg::FIFO_DEPTH];
  logic [POSITION_BITS-1:0] q_start  [ssl_pkg::FIFO_DEPTH];
  logic [POSITION_BITS-1:0] q_len    [ssl_pkg::FIFO_DEPTH];
  logic [1:0]               q_status [ssl_pkg::FIFO_DEPTH];
  logic                     q_done   [ssl_pkg::FIFO_DEPTH];

  logic [ssl_pkg::FIFO_PTR_BITS-1:0] wp_q, rp_q, wp1;
  logic [ssl_pkg::FIFO_CNT_BITS-1:0] cnt_q, push_cnt;
  logic                              out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign in_ready_o  = (cnt_q <= ssl_pkg::FIFO_CNT_BITS'(ssl_pkg::FIFO_DEPTH - 2));
  assign out_fire    = out_valid_o && out_ready_i;
  assign wp1         = wp_q + ssl_pkg::FIFO_PTR_BITS'(1);
  assign push_cnt    = in_fire ? (ssl_pkg::FIFO_CNT_BITS'(tok_valid) +
                                  ssl_pkg::FIFO_CNT_BITS'(end_valid)) : '0;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (tok_valid) begin
        q_kind[wp_q]   <= tok_kind;
        q_kw[wp_q]     <= tok_kw_idx;
        q_start[wp_q]  <= tok_start;
        q_len[wp_q]    <= tok_len;
        q_status[wp_q] <= ssl_pkg::STATUS_OK;
        q_done[wp_q]   <= 1'b0;
        if (end_valid) begin
          q_kind[wp1]   <= ssl_pkg::KIND_END;
          q_kw[wp1]     <= 1'b0;
          q_start[wp1]  <= end_start;
          q_len[wp1]    <= end_len;
          q_status[wp1] <= end_status;
          q_done[wp1]   <= 1'b1;
        end
      end else if (end_valid) begin
        q_kind[wp_q]   <= ssl_pkg::KIND_END;
        q_kw[wp_q]     <= 1'b0;
        q_start[wp_q]  <= end_start;
        q_len[wp_q]    <= end_len;
        q_status[wp_q] <= end_status;
        q_done[wp_q]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_cnt[ssl_pkg::FIFO_PTR_BITS-1:0];
      rp_q  <= rp_q + ssl_pkg::FIFO_PTR_BITS'(out_fire);
      cnt_q <= cnt_q + push_cnt - ssl_pkg::FIFO_CNT_BITS'(out_fire);
    end
  end

  assign token_kind_o    = q_kind[rp_q];
  assign keyword_index_o = q_kw[rp_q];
  assign token_start_o   = q_start[rp_q];
  assign token_length_o  = q_len[rp_q];
  assign parse_status_o  = q_status[rp_q];
  assign stream_done_o   = q_done[rp_q];

endmodule

### rtl/core/ssl_checker.sv
// Port-level checks of the lexer, bound to its top level
`include "symbol_string_lexer_macros.svh"

module ssl_checker #(
  parameter int POSITION_BITS = ssl_pkg::POSITION_BITS_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               token_kind_o,
  input logic                     keyword_index_o,
  input logic [POSITION_BITS-1:0] token_start_o,
  input logic [1:0]               parse_status_o,
  input logic                     stream_done_o
);

  `SSL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(token_start_o))
  `SSL_ASSERT_NOW(a_done_is_end, out_valid_o && stream_done_o,
                  token_kind_o == ssl_pkg::KIND_END)
  `SSL_ASSERT_NOW(a_token_clean, out_valid_o && (token_kind_o != ssl_pkg::KIND_END),
                  !stream_done_o && (parse_status_o == ssl_pkg::STATUS_OK))
  `SSL_ASSERT_NOW(a_index_known, out_valid_o && keyword_index_o,
                  (token_kind_o == ssl_pkg::KIND_KNOWN) &&
                  (parse_status_o != ssl_pkg::STATUS_UNUSED))

endmodule

bind symbol_string_lexer ssl_checker #(.POSITION_BITS(POSITION_BITS)) u_ssl_checker (.*);

### dv/symbol_string_lexer_tb.sv
// Testbench for the symbol and string lexer: directed and random byte streams, scoreboarded
`timescale 1ns / 100ps

module symbol_string_lexer_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 560;
  localparam int MAX_REPORTS    = 10;
  localparam logic [ssl_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 8'd4;
  localparam logic [ssl_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 8'hFF;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic        kw_idx;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  status;
    logic        done;
  } token_t;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [ssl_pkg::CFG_INDEX_BITS-1:0] cfg_index_i   = '0;
  logic [ssl_pkg::CFG_DATA_BITS-1:0]  cfg_data_i    = '0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_ready_o;
  logic [7:0]                         text_byte_i   = '0;
  logic                               end_of_text_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i   = 1'b0;
  logic [1:0]                         token_kind_o;
  logic                               keyword_index_o;
  logic [15:0]                        token_start_o;
  logic [15:0]                        token_length_o;
  logic [1:0]                         parse_status_o;
  logic                               stream_done_o;

  ssl_pkg::mode_e scan_mode;
  logic [15:0]    byte_pos;
  logic [15:0]    tok_start;
  logic [15:0]    run_len;
  logic [63:0]    prefix;
  logic [63:0]    kw_text [2];
  logic [3:0]     kw_len [2];
  token_t         pending_tokens [$];

  logic [63:0] pick_text [2];
  logic [3:0]  pick_len [2];
  logic [7:0]  stream_bytes [$];

  int mismatch_count = 0;
  int lexed_bytes    = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 38;
  int recv_idle_pct  = 50;

  symbol_string_lexer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_kind_o    (token_kind_o),
    .keyword_index_o (keyword_index_o),
    .token_start_o   (token_start_o),
    .token_length_o  (token_length_o),
    .parse_status_o  (parse_status_o),
    .stream_done_o   (stream_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == POS_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic symbol_byte(input logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E && c != ssl_pkg::CHAR_QUOTE && c != 8'h5B && c != 8'h5D;
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void clear_scan();
    scan_mode = ssl_pkg::MODE_IDLE;
    byte_pos  = '0;
    tok_start = '0;
    run_len   = '0;
    prefix    = '0;
  endfunction

  function automatic void push_token(input logic [1:0] kind, input logic idx,
                                     input logic [15:0] start, input logic [15:0] length,
                                     input logic [1:0] status, input logic done);
    token_t t;
    t.kind   = kind;
    t.kw_idx = idx;
    t.start  = start;
    t.length = length;
    t.status = status;
    t.done   = done;
    pending_tokens.push_back(t);
  endfunction

  function automatic logic keyword_hit(input int k);
    logic [63:0] mask;
    if (kw_len[k] == 4'd0 || kw_len[k] > ssl_pkg::KEYWORD_BYTES_DEF ||
        run_len != {12'd0, kw_len[k]})
      return 1'b0;
    mask = (kw_len[k] == 4'd8) ? '1 : ((64'd1 << (8 * kw_len[k])) - 64'd1);
    return ((kw_text[k] ^ prefix) & mask) == 64'd0;
  endfunction

  function automatic void push_symbol();
    if (keyword_hit(0))
      push_token(ssl_pkg::KIND_KNOWN, 1'b0, tok_start, run_len, ssl_pkg::STATUS_OK, 1'b0);
    else if (keyword_hit(1))
      push_token(ssl_pkg::KIND_KNOWN, 1'b1, tok_start, run_len, ssl_pkg::STATUS_OK, 1'b0);
    else
      push_token(ssl_pkg::KIND_SYMBOL, 1'b0, tok_start, run_len, ssl_pkg::STATUS_OK, 1'b0);
  endfunction

  function automatic void apply_config(input logic [ssl_pkg::CFG_INDEX_BITS-1:0] idx,
                                       input logic [ssl_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      ssl_pkg::REG_KW0_TEXT: kw_text[0] = data;
      ssl_pkg::REG_KW0_LEN:  kw_len[0]  = data[ssl_pkg::KW_LEN_BITS-1:0];
      ssl_pkg::REG_KW1_TEXT: kw_text[1] = data;
      ssl_pkg::REG_KW1_LEN:  kw_len[1]  = data[ssl_pkg::KW_LEN_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic last);
    logic [15:0] pos;
    logic        handled;
    pos     = byte_pos;
    handled = 1'b0;
    if (scan_mode == ssl_pkg::MODE_FAILED) begin
      if (last) clear_scan();
      return;
    end
    lexed_bytes++;
    if (scan_mode == ssl_pkg::MODE_STRING) begin
      if (c == ssl_pkg::CHAR_QUOTE) begin
        push_token(ssl_pkg::KIND_STRING, 1'b0, tok_start, run_len, ssl_pkg::STATUS_OK, 1'b0);
        scan_mode = ssl_pkg::MODE_IDLE;
      end else begin
        run_len = bump(run_len);
      end
      handled = 1'b1;
    end else if (scan_mode == ssl_pkg::MODE_SYMBOL) begin
      if (symbol_byte(c)) begin
        if (run_len < 16'd8) prefix[8 * run_len[2:0] +: 8] = c;
        run_len = bump(run_len);
        handled = 1'b1;
      end else begin
        push_symbol();
        scan_mode = ssl_pkg::MODE_IDLE;
      end
    end
    if (!handled) begin
      if (blank_byte(c)) begin
      end else if (c == ssl_pkg::CHAR_QUOTE) begin
        scan_mode = ssl_pkg::MODE_STRING;
        tok_start = pos;
        run_len   = '0;
      end else if (symbol_byte(c) && !digit_byte(c)) begin
        scan_mode = ssl_pkg::MODE_SYMBOL;
        tok_start = pos;
        run_len   = 16'd1;
        prefix    = {56'd0, c};
      end else begin
        push_token(ssl_pkg::KIND_END, 1'b0, pos, 16'd0, ssl_pkg::STATUS_UNKNOWN, 1'b1);
        scan_mode = ssl_pkg::MODE_FAILED;
      end
    end
    byte_pos = bump(pos);
    if (scan_mode == ssl_pkg::MODE_FAILED) begin
      if (last) clear_scan();
      return;
    end
    if (last) begin
      if (scan_mode == ssl_pkg::MODE_STRING) begin
        push_token(ssl_pkg::KIND_END, 1'b0, tok_start, run_len, ssl_pkg::STATUS_NOQUOTE, 1'b1);
      end else begin
        if (scan_mode == ssl_pkg::MODE_SYMBOL) push_symbol();
        push_token(ssl_pkg::KIND_END, 1'b0, byte_pos, 16'd0, ssl_pkg::STATUS_OK, 1'b1);
      end
      clear_scan();
    end
  endfunction

  function automatic string fmt_token(input token_t t);
    return $sformatf("kind %0d kw %0d start %0d length %0d status %0d done %0d",
                     t.kind, t.kw_idx, t.start, t.length, t.status, t.done);
  endfunction

  function automatic void check_token();
    token_t got;
    token_t want;
    got.kind   = token_kind_o;
    got.kw_idx = keyword_index_o;
    got.start  = token_start_o;
    got.length = token_length_o;
    got.status = parse_status_o;
    got.done   = stream_done_o;
    if (pending_tokens.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected token: %s", fmt_token(got));
      return;
    end
    want = pending_tokens.pop_front();
    if (got.kind !== want.kind || got.kw_idx !== want.kw_idx || got.start !== want.start ||
        got.length !== want.length || got.status !== want.status || got.done !== want.done) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("token mismatch: expected %s, got %s", fmt_token(want), fmt_token(got));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_config(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) lex_byte(text_byte_i, end_of_text_i);
      if (out_valid_o && out_ready_i) check_token();
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[symbol_string_lexer] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= c;
    end_of_text_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++)
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    stream_bytes.delete();
  endtask

  task automatic write_reg(input logic [ssl_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [ssl_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_sym(input logic lead);
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E));
    while (!symbol_byte(c) || (lead && digit_byte(c)));
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    int v;
    v = $urandom_range(0, 5);
    return (v == 5) ? 8'h20 : 8'(8'h09 + v);
  endfunction

  function automatic logic [7:0] rand_content();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ssl_pkg::CHAR_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] rand_bad();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (blank_byte(c) || c == ssl_pkg::CHAR_QUOTE || (symbol_byte(c) && !digit_byte(c)));
    return c;
  endfunction

  task automatic randomize_keywords();
    logic [63:0] text;
    logic [63:0] data;
    logic [3:0]  len;
    int          r;
    for (int k = 0; k < 2; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) len = 4'd0;
      else if (r <= 2) len = 4'd8;
      else if (r == 3) len = 4'($urandom_range(9, 15));
      else len = 4'($urandom_range(1, 7));
      text = {$urandom, $urandom};
      for (int i = 0; i < len && i < 8; i++) text[8 * i +: 8] = rand_sym(i == 0);
      pick_text[k] = text;
      pick_len[k]  = len;
      data = {$urandom, $urandom};
      data[3:0] = len;
      write_reg(k ? ssl_pkg::REG_KW1_TEXT : ssl_pkg::REG_KW0_TEXT, text);
      write_reg(k ? ssl_pkg::REG_KW1_LEN : ssl_pkg::REG_KW0_LEN, data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void build_stream();
    int r;
    int k;
    int n;
    stream_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      n = $urandom_range(1, 8);
      repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        repeat ($urandom_range(1, 3)) stream_bytes.push_back(rand_blank());
      end else if (r < 60) begin
        k = $urandom_range(0, 1);
        if ($urandom_range(0, 2) == 0 && pick_len[k] != 4'd0 && pick_len[k] <= 4'd8) begin
          for (int i = 0; i < pick_len[k]; i++) stream_bytes.push_back(pick_text[k][8 * i +: 8]);
          r = $urandom_range(0, 2);
          if (r == 1) stream_bytes.push_back(rand_sym(1'b0));
          else if (r == 2 && pick_len[k] > 4'd1) void'(stream_bytes.pop_back());
        end else begin
          n = $urandom_range(1, 10);
          stream_bytes.push_back(rand_sym(1'b1));
          repeat (n - 1) stream_bytes.push_back(rand_sym(1'b0));
        end
      end else begin
        stream_bytes.push_back(ssl_pkg::CHAR_QUOTE);
        repeat ($urandom_range(0, 8)) stream_bytes.push_back(rand_content());
        stream_bytes.push_back(ssl_pkg::CHAR_QUOTE);
      end
      if ($urandom_range(0, 1) == 1) stream_bytes.push_back(rand_blank());
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      stream_bytes.push_back(rand_bad());
      repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 14) begin
      stream_bytes.push_back(ssl_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 4)) stream_bytes.push_back(rand_content());
    end
  endfunction

  task automatic test_token_kinds();
    send_text("ab \"c d\"e\"\"");
    send_text("\t\n\v\f\015 z~");
    send_text("\"\"");
    send_text("  ");
    drain();
  endtask

  task automatic test_errors();
    send_text("7ab");
    send_text("x [y");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("\"abc");
    drain();
  endtask

  task automatic test_keywords();
    write_reg(ssl_pkg::REG_KW0_TEXT, 64'h61);
    write_reg(ssl_pkg::REG_KW0_LEN, 64'hFFFF_FFFF_FFFF_FFF1);
    write_reg(ssl_pkg::REG_KW1_TEXT, 64'h3F21_6164_626D_616C);
    write_reg(ssl_pkg::REG_KW1_LEN, 64'd8);
    write_reg(REG_SPARE_LO, '1);
    cfg_valid_i <= 1'b0;
    send_text("a ab lambda!? lambda!?x");
    drain();
    write_reg(ssl_pkg::REG_KW0_LEN, 64'd0);
    write_reg(ssl_pkg::REG_KW1_LEN, 64'd9);
    write_reg(REG_SPARE_HI, 64'd2);
    cfg_valid_i <= 1'b0;
    send_text("a lambda!?");
    drain();
    write_reg(ssl_pkg::REG_KW1_TEXT, '1);
    write_reg(ssl_pkg::REG_KW1_LEN, 64'd15);
    write_reg(ssl_pkg::REG_KW0_TEXT, 64'd0);
    write_reg(ssl_pkg::REG_KW0_LEN, 64'd8);
    cfg_valid_i <= 1'b0;
    send_text("a lambda!?");
    drain();
  endtask

  task automatic test_random_streams(input int send_pct, input int recv_pct);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    randomize_keywords();
    goal = lexed_bytes + RANDOM_BYTES;
    while (lexed_bytes < goal) begin
      build_stream();
      send_stream();
    end
    drain();
  endtask

  initial begin
    clear_scan();
    kw_text[0] = '0;
    kw_text[1] = '0;
    kw_len[0]  = '0;
    kw_len[1]  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_token_kinds();
    test_errors();
    test_keywords();
    test_random_streams(38, 50);
    test_random_streams(50, 38);
    test_random_streams(0, 0);
    if (mismatch_count == 0 && pending_tokens.size() == 0)
      $display("[symbol_string_lexer] OK");
    else
      $display("[symbol_string_lexer] ERROR");
    $finish;
  end

endmodule
